// File: design/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared constants, word types and controller/datapath interface types of
// the page span allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  // Pool geometry.
  localparam int MAX_SPAN_PAGES = 128;
  localparam int POOL_PAGES     = 4096;
  localparam int PAGE_W         = 12;
  localparam int LEN_W          = 7;
  localparam int LINK_W         = 13;
  localparam int IDX_W          = 8;
  localparam int HEAD_AW        = 7;

  localparam logic [LINK_W-1:0] NIL_LINK    = LINK_W'(POOL_PAGES);
  localparam logic [LEN_W-1:0]  BIG_SPAN    = LEN_W'(MAX_SPAN_PAGES - 1);
  localparam logic [LINK_W-1:0] LIMIT_RESET = LINK_W'(POOL_PAGES);

  // Request codes.
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_POOL_OUT = 2'd2;
  localparam logic [1:0] ST_NO_SPAN  = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [LEN_W-1:0]  page_count;
    logic [PAGE_W-1:0] page_number;
  } psa_in_t;

  // Result word.
  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] span_start;
    logic [LEN_W-1:0]  span_pages;
  } psa_out_t;

  // Datapath commands issued by the controller.
  typedef enum logic [5:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ERR_SIZE,
    CMD_ERR_POOL,
    CMD_ERR_PAGE,
    CMD_RD_HEAD_CNT,
    CMD_INIT_SEARCH,
    CMD_INC_I,
    CMD_RD_HEAD_I,
    CMD_LATCH_EX,
    CMD_LATCH_SPLIT,
    CMD_RM_RD,
    CMD_RM_WR,
    CMD_SET_INUSE,
    CMD_SP_LEN,
    CMD_PU_RD,
    CMD_PU_W1,
    CMD_PU_W2,
    CMD_SP_MAP_INIT,
    CMD_MAP_STEP,
    CMD_CARVE,
    CMD_RD_REL,
    CMD_REL_INIT,
    CMD_RD_OWN_PREV,
    CMD_RD_OWN_NEXT,
    CMD_RD_NB,
    CMD_NB_LATCH,
    CMD_BK_ACC,
    CMD_FW_ACC,
    CMD_REL_MAP_INIT,
    CMD_REL_FIN,
    CMD_RD_OWN_PG,
    CMD_LK_OWN,
    CMD_LK_FIN,
    CMD_OUT_LOAD
  } psa_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       cnt_bad;
    logic       exact_ne;
    logic       search_end;
    logic       search_hit;
    logic       carve_fail;
    logic       carved;
    logic       pg_mapped;
    logic       rel_ok;
    logic       back_ok;
    logic       nb_merge;
    logic       fwd_ok;
    logic       map_last;
    logic       out_busy;
  } psa_stat_t;

endpackage

// File: design/psa_ram.sv
// ----------------------------------------------------------------------------
// psa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/psa_dp.sv
// ----------------------------------------------------------------------------
// psa_dp
// Datapath of the page span allocator: span tables, free-list links, list
// heads, bump pointer, working registers and the result register.
// ----------------------------------------------------------------------------
module psa_dp
  import psa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  psa_cmd_t            cmd,
  output psa_stat_t           stat,
  input  psa_in_t             in_data,
  input  logic                cfg_valid,
  input  logic [LINK_W-1:0]   cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psa_out_t            out_data
);

  // Working registers.
  psa_in_t              req_r, req_nxt;
  logic [PAGE_W-1:0]    s_r, s_nxt, p_r, p_nxt, op_s_r, op_s_nxt;
  logic [LEN_W-1:0]     n_r, n_nxt, pl_r, pl_nxt, op_len_r, op_len_nxt, mi_r, mi_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt;
  logic [LINK_W-1:0]    h_r, h_nxt, bump_r, bump_nxt, limit_r, limit_nxt;
  logic                 carved_r, carved_nxt;
  logic [MAX_SPAN_PAGES-1:0] ne_r, ne_nxt;
  psa_out_t             res_r, res_nxt, outq_r, outq_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Memory ports.
  logic              own_we, len_we, use_we, nxt_we, prv_we, head_we;
  logic [PAGE_W-1:0] own_waddr, own_raddr, len_waddr, len_raddr;
  logic [PAGE_W-1:0] use_waddr, use_raddr, nxt_waddr, nxt_raddr, prv_waddr, prv_raddr;
  logic [HEAD_AW-1:0] head_waddr, head_raddr;
  logic [PAGE_W-1:0] own_wdata, own_rdata;
  logic [LEN_W-1:0]  len_wdata, len_rdata;
  logic              use_wdata, use_rdata;
  logic [LINK_W-1:0] nxt_wdata, nxt_rdata, prv_wdata, prv_rdata, head_wdata, head_rdata;

  // Derived values.
  logic [LEN_W-1:0]   rest;
  logic [PAGE_W-1:0]  tail;
  logic [LINK_W-1:0]  head_val;
  logic [LINK_W-1:0]  limit_eff;
  logic [LINK_W:0]    carve_end;
  logic [IDX_W-1:0]   merge_sum;

  psa_ram #(.WIDTH(PAGE_W), .DEPTH(POOL_PAGES)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rdata));
  psa_ram #(.WIDTH(LEN_W), .DEPTH(POOL_PAGES)) u_length (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata));
  psa_ram #(.WIDTH(1), .DEPTH(POOL_PAGES)) u_inuse (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .raddr(use_raddr), .rdata(use_rdata));
  psa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_PAGES)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata));
  psa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_PAGES)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(prv_raddr), .rdata(prv_rdata));
  psa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_SPAN_PAGES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));

  // Shared arithmetic.
  assign rest      = i_r[LEN_W-1:0] - req_r.page_count;
  assign tail      = s_r + PAGE_W'(rest);
  assign head_val  = ne_r[op_len_r] ? head_rdata : NIL_LINK;
  assign limit_eff = (limit_r > LIMIT_RESET) ? LIMIT_RESET : limit_r;
  assign carve_end = {1'b0, bump_r} + (LINK_W+1)'(BIG_SPAN);
  assign merge_sum = IDX_W'(len_rdata) + IDX_W'(n_r);

  // Status toward the controller.
  always_comb begin
    stat.req_type   = req_r.req_type;
    stat.cnt_bad    = (req_r.page_count == '0) ||
                      (IDX_W'(req_r.page_count) >= IDX_W'(MAX_SPAN_PAGES));
    stat.exact_ne   = ne_r[req_r.page_count];
    stat.search_end = (i_r >= IDX_W'(MAX_SPAN_PAGES));
    stat.search_hit = ne_r[i_r[LEN_W-1:0]];
    stat.carve_fail = (carve_end > {1'b0, limit_eff});
    stat.carved     = carved_r;
    stat.pg_mapped  = ({1'b0, req_r.page_number} < bump_r);
    stat.rel_ok     = (own_rdata == req_r.page_number) && use_rdata;
    stat.back_ok    = (s_r != '0);
    stat.nb_merge   = !use_rdata && (merge_sum < IDX_W'(MAX_SPAN_PAGES));
    stat.fwd_ok     = (({1'b0, s_r} + LINK_W'(n_r)) < bump_r);
    stat.map_last   = (mi_r == op_len_r - LEN_W'(1));
    stat.out_busy   = out_valid_r && out_stall;
  end

  // Command decode: memory accesses and next register values.
  always_comb begin
    req_nxt = req_r;  s_nxt = s_r;  p_nxt = p_r;  op_s_nxt = op_s_r;
    n_nxt = n_r;  pl_nxt = pl_r;  op_len_nxt = op_len_r;  mi_nxt = mi_r;
    i_nxt = i_r;  h_nxt = h_r;  bump_nxt = bump_r;  carved_nxt = carved_r;
    ne_nxt = ne_r;  res_nxt = res_r;  outq_nxt = outq_r;
    limit_nxt = cfg_valid ? cfg_data : limit_r;
    out_valid_nxt = out_valid_r && out_stall;

    own_we = 1'b0;  own_waddr = op_s_r;  own_wdata = op_s_r;  own_raddr = req_r.page_number;
    len_we = 1'b0;  len_waddr = op_s_r;  len_wdata = op_len_r;  len_raddr = req_r.page_number;
    use_we = 1'b0;  use_waddr = s_r;  use_wdata = 1'b0;  use_raddr = req_r.page_number;
    nxt_we = 1'b0;  nxt_waddr = op_s_r;  nxt_wdata = head_val;  nxt_raddr = op_s_r;
    prv_we = 1'b0;  prv_waddr = op_s_r;  prv_wdata = NIL_LINK;  prv_raddr = op_s_r;
    head_we = 1'b0;  head_waddr = op_len_r;  head_wdata = nxt_rdata;  head_raddr = op_len_r;

    case (cmd)
      CMD_LOAD: begin
        req_nxt = in_data;
        carved_nxt = 1'b0;
      end
      CMD_ERR_SIZE: res_nxt = '{status: ST_BAD_SIZE, span_start: '0, span_pages: '0};
      CMD_ERR_POOL: res_nxt = '{status: ST_POOL_OUT, span_start: '0, span_pages: '0};
      CMD_ERR_PAGE: res_nxt = '{status: ST_NO_SPAN, span_start: '0, span_pages: '0};
      CMD_RD_HEAD_CNT: head_raddr = req_r.page_count;
      CMD_INIT_SEARCH: i_nxt = IDX_W'(req_r.page_count) + IDX_W'(1);
      CMD_INC_I: i_nxt = i_r + IDX_W'(1);
      CMD_RD_HEAD_I: head_raddr = i_r[LEN_W-1:0];
      CMD_LATCH_EX: begin
        s_nxt = head_rdata[PAGE_W-1:0];
        op_s_nxt = head_rdata[PAGE_W-1:0];
        op_len_nxt = req_r.page_count;
      end
      CMD_LATCH_SPLIT: begin
        s_nxt = head_rdata[PAGE_W-1:0];
        op_s_nxt = head_rdata[PAGE_W-1:0];
        op_len_nxt = i_r[LEN_W-1:0];
      end
      CMD_RM_RD: begin
        nxt_raddr = op_s_r;
        prv_raddr = op_s_r;
      end
      // Unlink op_s from list op_len using the links read last cycle.
      CMD_RM_WR: begin
        if (prv_rdata < NIL_LINK) begin
          nxt_we = 1'b1;
          nxt_waddr = prv_rdata[PAGE_W-1:0];
          nxt_wdata = nxt_rdata;
        end else begin
          head_we = 1'b1;
          head_wdata = nxt_rdata;
          ne_nxt[op_len_r] = (nxt_rdata < NIL_LINK);
        end
        if (nxt_rdata < NIL_LINK) begin
          prv_we = 1'b1;
          prv_waddr = nxt_rdata[PAGE_W-1:0];
          prv_wdata = prv_rdata;
        end
      end
      CMD_SET_INUSE: begin
        use_we = 1'b1;
        use_waddr = s_r;
        use_wdata = 1'b1;
        res_nxt = '{status: ST_OK, span_start: s_r, span_pages: req_r.page_count};
      end
      CMD_SP_LEN: begin
        len_we = 1'b1;
        len_waddr = s_r;
        len_wdata = rest;
        op_s_nxt = s_r;
        op_len_nxt = rest;
      end
      CMD_PU_RD: head_raddr = op_len_r;
      CMD_PU_W1: begin
        h_nxt = head_val;
        nxt_we = 1'b1;
        nxt_waddr = op_s_r;
        nxt_wdata = head_val;
        prv_we = 1'b1;
        prv_waddr = op_s_r;
        prv_wdata = NIL_LINK;
      end
      CMD_PU_W2: begin
        if (h_r < NIL_LINK) begin
          prv_we = 1'b1;
          prv_waddr = h_r[PAGE_W-1:0];
          prv_wdata = {1'b0, op_s_r};
        end
        head_we = 1'b1;
        head_wdata = {1'b0, op_s_r};
        ne_nxt[op_len_r] = 1'b1;
      end
      CMD_SP_MAP_INIT: begin
        s_nxt = tail;
        op_s_nxt = tail;
        op_len_nxt = req_r.page_count;
        mi_nxt = '0;
      end
      // One page of the span gets its owner each cycle.
      CMD_MAP_STEP: begin
        own_we = 1'b1;
        own_waddr = op_s_r + PAGE_W'(mi_r);
        own_wdata = op_s_r;
        len_we = 1'b1;
        len_waddr = op_s_r;
        len_wdata = op_len_r;
        mi_nxt = mi_r + LEN_W'(1);
      end
      CMD_CARVE: begin
        s_nxt = bump_r[PAGE_W-1:0];
        op_s_nxt = bump_r[PAGE_W-1:0];
        op_len_nxt = BIG_SPAN;
        mi_nxt = '0;
        bump_nxt = bump_r + LINK_W'(BIG_SPAN);
        carved_nxt = 1'b1;
        use_we = 1'b1;
        use_waddr = bump_r[PAGE_W-1:0];
        use_wdata = 1'b0;
      end
      CMD_RD_REL: begin
        own_raddr = req_r.page_number;
        len_raddr = req_r.page_number;
        use_raddr = req_r.page_number;
      end
      CMD_REL_INIT: begin
        s_nxt = req_r.page_number;
        n_nxt = len_rdata;
      end
      CMD_RD_OWN_PREV: own_raddr = s_r - PAGE_W'(1);
      CMD_RD_OWN_NEXT: own_raddr = s_r + PAGE_W'(n_r);
      CMD_RD_NB: begin
        p_nxt = own_rdata;
        len_raddr = own_rdata;
        use_raddr = own_rdata;
      end
      CMD_NB_LATCH: begin
        pl_nxt = len_rdata;
        op_s_nxt = p_r;
        op_len_nxt = len_rdata;
      end
      CMD_BK_ACC: begin
        n_nxt = n_r + pl_r;
        s_nxt = p_r;
      end
      CMD_FW_ACC: n_nxt = n_r + pl_r;
      CMD_REL_MAP_INIT: begin
        op_s_nxt = s_r;
        op_len_nxt = n_r;
        mi_nxt = '0;
      end
      CMD_REL_FIN: begin
        use_we = 1'b1;
        use_waddr = s_r;
        use_wdata = 1'b0;
        res_nxt = '{status: ST_OK, span_start: s_r, span_pages: n_r};
      end
      CMD_RD_OWN_PG: own_raddr = req_r.page_number;
      CMD_LK_OWN: begin
        s_nxt = own_rdata;
        len_raddr = own_rdata;
      end
      CMD_LK_FIN: res_nxt = '{status: ST_OK, span_start: s_r, span_pages: len_rdata};
      CMD_OUT_LOAD: begin
        out_valid_nxt = 1'b1;
        outq_nxt = res_r;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r <= '0;
      bump_r <= '0;
      limit_r <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      carved_r <= 1'b0;
    end else begin
      ne_r <= ne_nxt;
      bump_r <= bump_nxt;
      limit_r <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      carved_r <= carved_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r <= req_nxt;  s_r <= s_nxt;  p_r <= p_nxt;  op_s_r <= op_s_nxt;
    n_r <= n_nxt;  pl_r <= pl_nxt;  op_len_r <= op_len_nxt;  mi_r <= mi_nxt;
    i_r <= i_nxt;  h_r <= h_nxt;  res_r <= res_nxt;  outq_r <= outq_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = outq_r;

endmodule

// File: design/psa_ctrl.sv
// ----------------------------------------------------------------------------
// psa_ctrl
// Controller of the page span allocator: sequences the allocate, release and
// lookup flows and the shared unlink, push and remap routines.
// ----------------------------------------------------------------------------
module psa_ctrl
  import psa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  psa_stat_t stat,
  output psa_cmd_t  cmd
);

  typedef enum logic [27:0] {
    S_IDLE     = 28'h0000001,
    S_DISPATCH = 28'h0000002,
    S_EX_HEAD  = 28'h0000004,
    S_EX_FIN   = 28'h0000008,
    S_SEARCH   = 28'h0000010,
    S_SP_HEAD  = 28'h0000020,
    S_SP_LEN   = 28'h0000040,
    S_SP_MAP   = 28'h0000080,
    S_RM_RD    = 28'h0000100,
    S_RM_WR    = 28'h0000200,
    S_PU_RD    = 28'h0000400,
    S_PU_W1    = 28'h0000800,
    S_PU_W2    = 28'h0001000,
    S_MAP      = 28'h0002000,
    S_CV_PUSH  = 28'h0004000,
    S_REL_CHK  = 28'h0008000,
    S_BACK     = 28'h0010000,
    S_BK_OWN   = 28'h0020000,
    S_BK_CHK   = 28'h0040000,
    S_BK_ACC   = 28'h0080000,
    S_FWD      = 28'h0100000,
    S_FW_OWN   = 28'h0200000,
    S_FW_CHK   = 28'h0400000,
    S_FW_ACC   = 28'h0800000,
    S_REL_FIN  = 28'h1000000,
    S_LK_OWN   = 28'h2000000,
    S_LK_LEN   = 28'h4000000,
    S_DONE     = 28'h8000000
  } psa_state_t;

  psa_state_t state_r, state_nxt, ret_r, ret_nxt;

  // Next state, return point and command.
  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    cmd = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req_type)
          REQ_ALLOC: begin
            if (stat.cnt_bad) begin
              cmd = CMD_ERR_SIZE;
              state_nxt = S_DONE;
            end else if (stat.exact_ne) begin
              cmd = CMD_RD_HEAD_CNT;
              state_nxt = S_EX_HEAD;
            end else begin
              cmd = CMD_INIT_SEARCH;
              state_nxt = S_SEARCH;
            end
          end
          REQ_RELEASE: begin
            if (stat.pg_mapped) begin
              cmd = CMD_RD_REL;
              state_nxt = S_REL_CHK;
            end else begin
              cmd = CMD_ERR_PAGE;
              state_nxt = S_DONE;
            end
          end
          REQ_LOOKUP: begin
            if (stat.pg_mapped) begin
              cmd = CMD_RD_OWN_PG;
              state_nxt = S_LK_OWN;
            end else begin
              cmd = CMD_ERR_PAGE;
              state_nxt = S_DONE;
            end
          end
          default: begin
            cmd = CMD_ERR_SIZE;
            state_nxt = S_DONE;
          end
        endcase
      end
      // Exact-size hit: unlink the head and mark it in use.
      S_EX_HEAD: begin
        cmd = CMD_LATCH_EX;
        ret_nxt = S_EX_FIN;
        state_nxt = S_RM_RD;
      end
      S_EX_FIN: begin
        cmd = CMD_SET_INUSE;
        state_nxt = S_DONE;
      end
      // Look for the smallest larger list, one length per cycle.
      S_SEARCH: begin
        if (stat.search_end) begin
          if (stat.carved || stat.carve_fail) begin
            cmd = CMD_ERR_POOL;
            state_nxt = S_DONE;
          end else begin
            cmd = CMD_CARVE;
            ret_nxt = S_CV_PUSH;
            state_nxt = S_MAP;
          end
        end else if (stat.search_hit) begin
          cmd = CMD_RD_HEAD_I;
          state_nxt = S_SP_HEAD;
        end else begin
          cmd = CMD_INC_I;
        end
      end
      S_SP_HEAD: begin
        cmd = CMD_LATCH_SPLIT;
        ret_nxt = S_SP_LEN;
        state_nxt = S_RM_RD;
      end
      S_SP_LEN: begin
        cmd = CMD_SP_LEN;
        ret_nxt = S_SP_MAP;
        state_nxt = S_PU_RD;
      end
      S_SP_MAP: begin
        cmd = CMD_SP_MAP_INIT;
        ret_nxt = S_EX_FIN;
        state_nxt = S_MAP;
      end
      // Unlink routine.
      S_RM_RD: begin
        cmd = CMD_RM_RD;
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        cmd = CMD_RM_WR;
        state_nxt = ret_r;
      end
      // Push routine.
      S_PU_RD: begin
        cmd = CMD_PU_RD;
        state_nxt = S_PU_W1;
      end
      S_PU_W1: begin
        cmd = CMD_PU_W1;
        state_nxt = S_PU_W2;
      end
      S_PU_W2: begin
        cmd = CMD_PU_W2;
        state_nxt = ret_r;
      end
      // Remap routine.
      S_MAP: begin
        cmd = CMD_MAP_STEP;
        if (stat.map_last) begin
          state_nxt = ret_r;
        end
      end
      S_CV_PUSH: begin
        ret_nxt = S_DISPATCH;
        state_nxt = S_PU_RD;
      end
      // Release: validate, merge backward, then forward.
      S_REL_CHK: begin
        if (stat.rel_ok) begin
          cmd = CMD_REL_INIT;
          state_nxt = S_BACK;
        end else begin
          cmd = CMD_ERR_PAGE;
          state_nxt = S_DONE;
        end
      end
      S_BACK: begin
        if (stat.back_ok) begin
          cmd = CMD_RD_OWN_PREV;
          state_nxt = S_BK_OWN;
        end else begin
          state_nxt = S_FWD;
        end
      end
      S_BK_OWN: begin
        cmd = CMD_RD_NB;
        state_nxt = S_BK_CHK;
      end
      S_BK_CHK: begin
        if (stat.nb_merge) begin
          cmd = CMD_NB_LATCH;
          ret_nxt = S_BK_ACC;
          state_nxt = S_RM_RD;
        end else begin
          state_nxt = S_FWD;
        end
      end
      S_BK_ACC: begin
        cmd = CMD_BK_ACC;
        state_nxt = S_BACK;
      end
      S_FWD: begin
        if (stat.fwd_ok) begin
          cmd = CMD_RD_OWN_NEXT;
          state_nxt = S_FW_OWN;
        end else begin
          cmd = CMD_REL_MAP_INIT;
          ret_nxt = S_REL_FIN;
          state_nxt = S_MAP;
        end
      end
      S_FW_OWN: begin
        cmd = CMD_RD_NB;
        state_nxt = S_FW_CHK;
      end
      S_FW_CHK: begin
        if (stat.nb_merge) begin
          cmd = CMD_NB_LATCH;
          ret_nxt = S_FW_ACC;
          state_nxt = S_RM_RD;
        end else begin
          cmd = CMD_REL_MAP_INIT;
          ret_nxt = S_REL_FIN;
          state_nxt = S_MAP;
        end
      end
      S_FW_ACC: begin
        cmd = CMD_FW_ACC;
        state_nxt = S_FWD;
      end
      S_REL_FIN: begin
        cmd = CMD_REL_FIN;
        ret_nxt = S_DONE;
        state_nxt = S_PU_RD;
      end
      // Lookup: owner, then its length.
      S_LK_OWN: begin
        cmd = CMD_LK_OWN;
        state_nxt = S_LK_LEN;
      end
      S_LK_LEN: begin
        cmd = CMD_LK_FIN;
        state_nxt = S_DONE;
      end
      // Hand the result word to the output register once it is free.
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd = CMD_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: design/page_span_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_span_allocator_unit
// Page span allocator with per-length free lists and coalescing release.
// ----------------------------------------------------------------------------
// The unit takes one request word at a time and returns exactly one result
// word per request. A lookup reads the page owner and then its length. An
// exact-size allocate unlinks the list head and marks it in use. An allocate
// that splits a larger span searches the free lists by length, pushes the
// remainder back and then remaps the allocated pages; when a fresh 127-page
// span must first be carved, the 127 pages are remapped and the size search
// then runs a second time. A release unlinks each merged neighbor and then
// remaps every page of the merged span. The page owner memory is written one
// page per cycle during remapping, and the size search checks one free list
// per cycle. Pages below the bump pointer count as mapped, so no clearing
// pass follows reset. A result word may wait in the output register while
// the next request is taken. The pool limit register may be written at any
// time the unit is idle.
// ----------------------------------------------------------------------------
module page_span_allocator_unit
  import psa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psa_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psa_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LINK_W-1:0] cfg_data
);

  psa_cmd_t  cmd;
  psa_stat_t stat;

  // The limit register is always ready for a write.
  assign cfg_ready = 1'b1;

  psa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd));

  psa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data));

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page span allocator unit. A short table of
// directed words covers error codes, carving, splitting and merging; random
// traffic then runs four phases with different pool limits and idle patterns,
// and every result word is checked against a behavioral model of the pool.
// ----------------------------------------------------------------------------
module tb_top;
  import psa_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int NPHASE = 4;
  localparam int PHASE_WORDS = 185;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  psa_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  psa_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LINK_W-1:0] cfg_data = '0;

  page_span_allocator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Pool model state.
  int unsigned pg_owner [POOL_PAGES];
  bit          pg_mapped[POOL_PAGES];
  int unsigned sp_len   [POOL_PAGES];
  bit          sp_busy  [POOL_PAGES];
  int unsigned fl_next  [POOL_PAGES];
  int unsigned fl_prev  [POOL_PAGES];
  int unsigned fl_head  [MAX_SPAN_PAGES];
  int unsigned bump_pg;
  int unsigned lim_pages;

  // Expected result words and spans currently handed out.
  psa_out_t    exp_words[$];
  int unsigned live_spans[$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  localparam int NIL = POOL_PAGES;

  function automatic void free_push(int unsigned len, int unsigned s);
    int unsigned h;
    h = fl_head[len];
    fl_next[s] = h;
    fl_prev[s] = NIL;
    if (h < NIL) fl_prev[h] = s;
    fl_head[len] = s;
  endfunction

  function automatic void free_unlink(int unsigned len, int unsigned s);
    int unsigned p;
    int unsigned n;
    p = fl_prev[s];
    n = fl_next[s];
    if (p < NIL) fl_next[p] = n;
    else fl_head[len] = n;
    if (n < NIL) fl_prev[n] = p;
  endfunction

  function automatic void map_pages(int unsigned start, int unsigned len);
    for (int unsigned i = 0; i < len && start + i < POOL_PAGES; i++) begin
      pg_owner[start + i] = start;
      pg_mapped[start + i] = 1'b1;
    end
    sp_len[start] = len;
  endfunction

  // Take an exact free span, or split the tail off the smallest larger one.
  function automatic bit grab_span(int unsigned n, output int unsigned start);
    int unsigned s;
    int unsigned rest;
    s = fl_head[n];
    start = 0;
    if (s < NIL) begin
      free_unlink(n, s);
      sp_busy[s] = 1'b1;
      start = s;
      return 1'b1;
    end
    for (int unsigned i = n + 1; i < MAX_SPAN_PAGES; i++) begin
      s = fl_head[i];
      if (s < NIL) begin
        rest = i - n;
        free_unlink(i, s);
        sp_len[s] = rest;
        free_push(rest, s);
        map_pages(s + rest, n);
        sp_busy[s + rest] = 1'b1;
        start = s + rest;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < POOL_PAGES; i++) begin
      pg_owner[i] = 0;
      pg_mapped[i] = 1'b0;
      sp_len[i] = 0;
      sp_busy[i] = 1'b0;
      fl_next[i] = 0;
      fl_prev[i] = 0;
    end
    for (int i = 0; i < MAX_SPAN_PAGES; i++) fl_head[i] = NIL;
    bump_pg = 0;
    lim_pages = POOL_PAGES;
  endfunction

  function automatic void drop_live(int unsigned s);
    foreach (live_spans[i]) begin
      if (live_spans[i] == s) begin
        live_spans.delete(i);
        return;
      end
    end
  endfunction

  // Compute the result word of one request and update the pool model.
  function automatic psa_out_t pool_answer(psa_in_t w);
    psa_out_t    r;
    int unsigned cnt;
    int unsigned pg;
    int unsigned st;
    int unsigned lim;
    int unsigned s;
    int unsigned n;
    int unsigned p;
    int unsigned pl;
    r = '0;
    cnt = w.page_count;
    pg = w.page_number;
    r.status = ST_OK;
    case (w.req_type)
      REQ_ALLOC: begin
        if (cnt == 0 || cnt >= MAX_SPAN_PAGES) begin
          r.status = ST_BAD_SIZE;
        end else if (grab_span(cnt, st)) begin
          r.span_start = PAGE_W'(st);
          r.span_pages = LEN_W'(cnt);
        end else begin
          lim = (lim_pages > POOL_PAGES) ? POOL_PAGES : lim_pages;
          if (bump_pg + (MAX_SPAN_PAGES - 1) > lim) begin
            r.status = ST_POOL_OUT;
          end else begin
            // Carve a fresh maximal span at the bump pointer first.
            s = bump_pg;
            map_pages(s, MAX_SPAN_PAGES - 1);
            sp_busy[s] = 1'b0;
            free_push(MAX_SPAN_PAGES - 1, s);
            bump_pg += MAX_SPAN_PAGES - 1;
            if (grab_span(cnt, st)) begin
              r.span_start = PAGE_W'(st);
              r.span_pages = LEN_W'(cnt);
            end else begin
              r.status = ST_POOL_OUT;
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (!pg_mapped[pg] || pg_owner[pg] != pg || !sp_busy[pg]) begin
          r.status = ST_NO_SPAN;
        end else begin
          s = pg;
          n = sp_len[s];
          // Merge backward, then forward, while the sum stays below the max.
          while (s > 0 && pg_mapped[s - 1]) begin
            p = pg_owner[s - 1];
            pl = sp_len[p];
            if (sp_busy[p] || pl + n >= MAX_SPAN_PAGES) break;
            free_unlink(pl, p);
            n += pl;
            s = p;
          end
          while (s + n < POOL_PAGES && pg_mapped[s + n]) begin
            p = pg_owner[s + n];
            pl = sp_len[p];
            if (sp_busy[p] || pl + n >= MAX_SPAN_PAGES) break;
            free_unlink(pl, p);
            n += pl;
          end
          map_pages(s, n);
          sp_busy[s] = 1'b0;
          free_push(n, s);
          drop_live(pg);
          r.span_start = PAGE_W'(s);
          r.span_pages = LEN_W'(n);
        end
      end
      REQ_LOOKUP: begin
        if (!pg_mapped[pg]) begin
          r.status = ST_NO_SPAN;
        end else begin
          r.span_start = PAGE_W'(pg_owner[pg]);
          r.span_pages = LEN_W'(sp_len[pg_owner[pg]]);
        end
      end
      default: r.status = ST_BAD_SIZE;
    endcase
    if (r.status != ST_OK) begin
      r.span_start = '0;
      r.span_pages = '0;
    end else if (w.req_type == REQ_ALLOC) begin
      live_spans.push_back(r.span_start);
    end
    return r;
  endfunction

  // Send one request word; the expectation is queued when it is taken.
  task automatic send_word(psa_in_t w, bit typed, psa_out_t typed_exp);
    psa_out_t r;
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = pool_answer(w);
    exp_words.push_back(typed ? typed_exp : r);
  endtask

  // Random request, mostly well-formed allocate/release traffic.
  function automatic psa_in_t random_word();
    psa_in_t w;
    int unsigned k;
    int unsigned hi;
    w.req_type = REQ_ALLOC;
    w.page_count = LEN_W'($urandom_range(127));
    w.page_number = PAGE_W'($urandom_range(POOL_PAGES - 1));
    k = $urandom_range(99);
    if (k < 45) begin
      w.page_count = ($urandom_range(99) < 80) ? LEN_W'($urandom_range(16, 1))
                                               : LEN_W'($urandom_range(127, 1));
    end else if (k < 80) begin
      w.req_type = REQ_RELEASE;
      if (live_spans.size() > 0)
        w.page_number = PAGE_W'(live_spans[$urandom_range(live_spans.size() - 1)]);
    end else if (k < 95) begin
      w.req_type = REQ_LOOKUP;
      hi = (bump_pg + 8 < POOL_PAGES) ? bump_pg + 8 : POOL_PAGES - 1;
      if ($urandom_range(3) != 0) w.page_number = PAGE_W'($urandom_range(hi));
    end else begin
      case ($urandom_range(3))
        0: w.page_count = '0;
        1: w.page_count = LEN_W'(127);
        2: w.req_type = REQ_UNKNOWN;
        default: w.req_type = REQ_RELEASE;
      endcase
    end
    return w;
  endfunction

  task automatic write_limit(logic [LINK_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lim_pages = v;
  endtask

  task automatic wait_drained();
    while (exp_words.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    psa_out_t e;
    out_stall <= (rcv_stall_pct > 0) && ($urandom_range(99) < rcv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (exp_words.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result word %h", out_data);
      end else begin
        e = exp_words.pop_front();
        if (out_data.status != e.status || out_data.span_start != e.span_start ||
            out_data.span_pages != e.span_pages) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp st=%0d start=%0d pages=%0d, got st=%0d start=%0d pages=%0d",
                     e.status, e.span_start, e.span_pages,
                     out_data.status, out_data.span_start, out_data.span_pages);
        end
      end
    end
  end

  // Run time limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** page_span_allocator_unit: FAILED **");
      $finish;
    end
  end

  typedef struct {
    psa_in_t  w;
    bit       typed;
    psa_out_t r;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic void add_row(logic [1:0] req, int cnt, int pg, bit typed,
                                  logic [1:0] st, int start, int pages);
    stim_row_t row;
    row.w = '{req_type: req, page_count: LEN_W'(cnt), page_number: PAGE_W'(pg)};
    row.typed = typed;
    row.r = '{status: st, span_start: PAGE_W'(start), span_pages: LEN_W'(pages)};
    rows.push_back(row);
  endfunction

  // Main sequence.
  initial begin
    logic [LINK_W-1:0] phase_lim[NPHASE];
    int                phase_snd[NPHASE];
    int                phase_rcv[NPHASE];
    phase_lim = '{13'd8191, 13'd0, 13'd2000, 13'd4096};
    phase_snd = '{0, 77, 0, 13};
    phase_rcv = '{0, 0, 77, 13};
    pool_reset();

    // Directed table: typed results where they are obvious from the rules.
    add_row(REQ_LOOKUP,  0,   0,    1, ST_NO_SPAN,  0,   0);
    add_row(REQ_LOOKUP,  127, 4095, 1, ST_NO_SPAN,  0,   0);
    add_row(REQ_ALLOC,   0,   4095, 1, ST_BAD_SIZE, 0,   0);
    add_row(REQ_ALLOC,   127, 0,    1, ST_OK,       0,   127);
    add_row(REQ_RELEASE, 0,   0,    1, ST_OK,       0,   127);
    add_row(REQ_UNKNOWN, 5,   9,    1, ST_BAD_SIZE, 0,   0);
    add_row(REQ_RELEASE, 0,   0,    1, ST_NO_SPAN,  0,   0);
    add_row(REQ_ALLOC,   1,   0,    1, ST_OK,       126, 1);
    add_row(REQ_ALLOC,   126, 0,    1, ST_OK,       0,   126);
    add_row(REQ_LOOKUP,  0,   126,  1, ST_OK,       126, 1);
    add_row(REQ_RELEASE, 0,   126,  1, ST_OK,       126, 1);
    add_row(REQ_RELEASE, 0,   126,  1, ST_NO_SPAN,  0,   0);
    add_row(REQ_RELEASE, 0,   0,    1, ST_OK,       0,   127);
    add_row(REQ_RELEASE, 0,   4095, 1, ST_NO_SPAN,  0,   0);
    add_row(REQ_ALLOC,   64,  0,    0, ST_OK,       0,   0);
    add_row(REQ_ALLOC,   63,  0,    0, ST_OK,       0,   0);
    add_row(REQ_ALLOC,   100, 0,    0, ST_OK,       0,   0);
    add_row(REQ_ALLOC,   27,  0,    0, ST_OK,       0,   0);
    add_row(REQ_RELEASE, 0,   5,    0, ST_OK,       0,   0);
    add_row(REQ_RELEASE, 0,   63,   0, ST_OK,       0,   0);
    add_row(REQ_RELEASE, 0,   0,    0, ST_OK,       0,   0);
    add_row(REQ_LOOKUP,  0,   200,  0, ST_OK,       0,   0);
    add_row(REQ_RELEASE, 0,   127,  0, ST_OK,       0,   0);
    add_row(REQ_LOOKUP,  0,   253,  0, ST_OK,       0,   0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(LIMIT_RESET);

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);
    in_valid <= 1'b0;

    // Random phases, each with its own limit and idle pattern.
    for (int ph = 0; ph < NPHASE; ph++) begin
      wait_drained();
      snd_idle_pct = 0;
      rcv_stall_pct = 0;
      @(posedge clk);
      write_limit(phase_lim[ph]);
      snd_idle_pct = phase_snd[ph];
      rcv_stall_pct = phase_rcv[ph];
      for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_words.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("** page_span_allocator_unit: PASSED **");
    end else begin
      $display("** page_span_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/psa_pkg.sv
design/psa_ram.sv
design/psa_dp.sv
design/psa_ctrl.sv
design/page_span_allocator_unit.sv
bench/tb_top.sv
